// File: design/tpd_pkg.sv
`timescale 1ns / 1ps
package tpd_pkg;

  localparam logic [7:0] HDR_ANGLE = 8'b1000_0011;
  localparam logic [7:0] HDR_RATE  = 8'b1111_1100;
  localparam logic [7:0] HDR_INFO  = 8'b1000_0100;
  localparam logic [7:0] BYTE_END  = 8'b1010_0000;
  localparam logic [7:0] BYTE_FAIL = 8'b1111_1111;

  localparam logic [8:0] CHECK_MOD = 9'd255;

  localparam int PAYLOAD_DEPTH = 12;
  localparam int COUNT_W       = 4;
  localparam logic [COUNT_W-1:0] ANGLE_BODY_LAST = 4'd6;
  localparam logic [COUNT_W-1:0] RATE_BODY_LAST  = 4'd12;
  localparam logic [COUNT_W-1:0] STORE_LIMIT     = 4'd12;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] EXP_ALL_ONES = 8'hFF;
  localparam logic [7:0] EXP_BIAS     = 8'd127;
  localparam logic [7:0] EXP_SAT      = 8'd31;
  localparam logic [7:0] MANT_BITS    = 8'd23;

  typedef enum logic [1:0] {
    KIND_ANGLES  = 2'd0,
    KIND_RATES   = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_FAIL    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [95:0] data;
    logic [7:0]  check;
  } job_t;

  // Magnitude of a single value truncated towards zero, saturating at 2^31-1.
  function automatic logic [30:0] trunc_mag(input logic [31:0] bits);
    logic [7:0]  expo;
    logic [7:0]  e;
    logic [30:0] mant;
    expo = bits[30:23];
    e    = expo - EXP_BIAS;
    mant = {7'b0, 1'b1, bits[22:0]};
    if (expo == EXP_ALL_ONES) begin
      return '1;
    end else if (expo < EXP_BIAS) begin
      return '0;
    end else if (e >= EXP_SAT) begin
      return '1;
    end else if (e >= MANT_BITS) begin
      return mant << (e - MANT_BITS);
    end else begin
      return mant >> (MANT_BITS - e);
    end
  endfunction

  function automatic logic [9:0] byte_sum4(input logic [31:0] w);
    return 10'(w[7:0]) + 10'(w[15:8]) + 10'(w[23:16]) + 10'(w[31:24]);
  endfunction

endpackage

// File: design/tpd_if.sv
`timescale 1ns / 1ps
interface tpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface tpd_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         packet_kind;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] roll_angle;
  logic signed [15:0] yaw_angle;
  logic [31:0]        pitch_rate_bits;
  logic [31:0]        roll_rate_bits;
  logic [31:0]        yaw_rate_bits;

  modport source (output valid, output packet_kind, output pitch_angle, output roll_angle,
                  output yaw_angle, output pitch_rate_bits, output roll_rate_bits,
                  output yaw_rate_bits, input ready);
  modport sink (input valid, input packet_kind, input pitch_angle, input roll_angle,
                input yaw_angle, input pitch_rate_bits, input roll_rate_bits,
                input yaw_rate_bits, output ready);
endinterface

// File: design/telemetry_packet_deframer_core.sv
`timescale 1ns / 1ps
// A packet's request passes through the job queue, the check register and the output register.
// Throughput: one byte per cycle; the byte input stalls only when the two-entry job queue
// is full, which happens only while the result output is held back by its consumer.
// Reset: rst_n is synchronous and active low; it returns the parser to header hunting and
// empties the job queue and the checking pipeline. The payload store is not cleared.
module telemetry_packet_deframer_core
  import tpd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  tpd_byte_if.sink     in_ch,
  tpd_result_if.source out_ch
);

  logic job_push;
  job_t job_push_data;
  logic job_full;
  logic job_pop;
  job_t job_pop_data;
  logic job_empty;

  tpd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_ch.valid),
    .byte_data  (in_ch.rx_byte),
    .byte_ready (in_ch.ready),
    .job_full   (job_full),
    .job_push   (job_push),
    .job_data   (job_push_data)
  );

  tpd_job_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_push_data),
    .full      (job_full),
    .pop       (job_pop),
    .pop_data  (job_pop_data),
    .empty     (job_empty)
  );

  tpd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job_data  (job_pop_data),
    .job_pop   (job_pop),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> !job_full)
    else $error("request pushed into a full job queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> !job_empty)
    else $error("request popped from an empty job queue");

  a_angle_zero_rates: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.packet_kind == KIND_ANGLES) |->
      (out_ch.pitch_rate_bits == '0 && out_ch.roll_rate_bits == '0 &&
       out_ch.yaw_rate_bits == '0))
    else $error("angle request carries rate data");

  a_event_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.packet_kind == KIND_RESTART || out_ch.packet_kind == KIND_FAIL))
      |-> (out_ch.pitch_angle == '0 && out_ch.roll_angle == '0 && out_ch.yaw_angle == '0 &&
           out_ch.pitch_rate_bits == '0))
    else $error("event request carries data");
`endif

endmodule

// File: design/tpd_front.sv
`timescale 1ns / 1ps
module tpd_front
  import tpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_valid,
  input  logic [7:0] byte_data,
  output logic       byte_ready,
  input  logic       job_full,
  output logic       job_push,
  output job_t       job_data
);

  typedef enum logic [3:0] {
    ST_HUNT  = 4'b0001,
    ST_ANGLE = 4'b0010,
    ST_RATE  = 4'b0100,
    ST_INFO  = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [7:0]           store_r [PAYLOAD_DEPTH];
  logic [95:0]          packed_store;
  logic                 take;
  logic                 in_body;

  function automatic state_t hunt(input logic [7:0] b);
    case (b)
      HDR_ANGLE: return ST_ANGLE;
      HDR_RATE:  return ST_RATE;
      HDR_INFO:  return ST_INFO;
      default:   return ST_HUNT;
    endcase
  endfunction

  assign byte_ready = !job_full;
  assign take       = byte_valid && byte_ready;
  assign in_body    = (state_r == ST_ANGLE) || (state_r == ST_RATE);

  always_comb begin
    for (int i = 0; i < PAYLOAD_DEPTH; i++) begin
      packed_store[8*i +: 8] = store_r[i];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    job_push       = 1'b0;
    job_data.kind  = KIND_ANGLES;
    job_data.data  = packed_store;
    job_data.check = byte_data;
    if (take) begin
      case (state_r)
        ST_HUNT: begin
          state_nxt = hunt(byte_data);
          count_nxt = '0;
        end
        ST_INFO: begin
          count_nxt = '0;
          if (byte_data == BYTE_END || byte_data == BYTE_FAIL) begin
            job_push      = 1'b1;
            job_data.kind = (byte_data == BYTE_END) ? KIND_RESTART : KIND_FAIL;
            state_nxt     = ST_HUNT;
          end else begin
            state_nxt = hunt(byte_data);
          end
        end
        ST_ANGLE: begin
          count_nxt = count_r + 1'b1;
          if (count_r == ANGLE_BODY_LAST) begin
            job_push  = 1'b1;
            state_nxt = ST_HUNT;
            count_nxt = '0;
          end
        end
        ST_RATE: begin
          count_nxt = count_r + 1'b1;
          if (count_r == RATE_BODY_LAST) begin
            job_push      = 1'b1;
            job_data.kind = KIND_RATES;
            state_nxt     = ST_HUNT;
            count_nxt     = '0;
          end
        end
        default: begin
          state_nxt = ST_HUNT;
          count_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_body && count_r < STORE_LIMIT) begin
      store_r[count_r] <= byte_data;
    end
  end

endmodule

// File: design/tpd_job_fifo.sv
`timescale 1ns / 1ps
module tpd_job_fifo
  import tpd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output job_t pop_data,
  output logic empty
);

  job_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0] count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign full     = (count_r == FIFO_CW'(FIFO_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: design/tpd_back.sv
`timescale 1ns / 1ps
module tpd_back
  import tpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_empty,
  input  job_t        job_data,
  output logic        job_pop,
  tpd_result_if.source out_ch
);

  logic        a_valid_r, a_valid_nxt;
  job_t        a_job_r;
  logic [95:0] a_terms_r;
  logic [95:0] terms;
  logic        a_adv;
  logic        a_load;

  logic        out_valid_r, out_valid_nxt;
  kind_t       out_kind_r;
  logic [15:0] out_angle_r [3];
  logic [31:0] out_rate_r [3];
  logic [15:0] out_angle_nxt [3];
  logic [31:0] out_rate_nxt [3];

  logic [11:0] total;
  logic [8:0]  folded;
  logic [7:0]  residue;
  logic        pass;

  assign a_adv   = !out_valid_r || out_ch.ready;
  assign a_load  = !a_valid_r || a_adv;
  assign job_pop = a_load && !job_empty;

  // The check sum modulo 255 equals the byte sum modulo 255, as 256 is 1 modulo 255.
  always_comb begin
    case (job_data.kind)
      KIND_ANGLES: terms = {48'b0, job_data.data[47:0]};
      KIND_RATES: begin
        terms = {1'b0, trunc_mag(job_data.data[95:64]),
                 1'b0, trunc_mag(job_data.data[63:32]),
                 1'b0, trunc_mag(job_data.data[31:0])};
      end
      default: terms = '0;
    endcase
  end

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (a_load) begin
      a_valid_nxt = !job_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      a_job_r   <= job_data;
      a_terms_r <= terms;
    end
  end

  always_comb begin
    total   = 12'(byte_sum4(a_terms_r[31:0])) + 12'(byte_sum4(a_terms_r[63:32]))
            + 12'(byte_sum4(a_terms_r[95:64]));
    folded  = 9'(total[11:8]) + 9'(total[7:0]);
    residue = (folded >= CHECK_MOD) ? 8'(folded - CHECK_MOD) : folded[7:0];
    case (a_job_r.kind)
      KIND_ANGLES, KIND_RATES: pass = (residue == a_job_r.check);
      default:                 pass = 1'b1;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (a_adv) begin
      out_valid_nxt = a_valid_r && pass;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      out_angle_nxt[i] = '0;
      out_rate_nxt[i]  = '0;
    end
    case (a_job_r.kind)
      KIND_ANGLES: begin
        for (int i = 0; i < 3; i++) begin
          out_angle_nxt[i] = {~a_job_r.data[16*i + 7], a_job_r.data[16*i +: 7],
                              a_job_r.data[16*i + 8 +: 8]};
        end
      end
      KIND_RATES: begin
        for (int i = 0; i < 3; i++) begin
          out_rate_nxt[i] = a_job_r.data[32*i +: 32];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (a_adv && a_valid_r) begin
      out_kind_r <= a_job_r.kind;
      for (int i = 0; i < 3; i++) begin
        out_angle_r[i] <= out_angle_nxt[i];
        out_rate_r[i]  <= out_rate_nxt[i];
      end
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.packet_kind     = out_kind_r;
  assign out_ch.pitch_angle     = signed'(out_angle_r[0]);
  assign out_ch.roll_angle      = signed'(out_angle_r[1]);
  assign out_ch.yaw_angle       = signed'(out_angle_r[2]);
  assign out_ch.pitch_rate_bits = out_rate_r[0];
  assign out_ch.roll_rate_bits  = out_rate_r[1];
  assign out_ch.yaw_rate_bits   = out_rate_r[2];

endmodule
